// ===== design/u2u_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u_pkg: shared types and constants of the UTF-8 to UTF-16 converter
// Widths, result kinds, queue sizing and the job record passed front to back.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int COUNT_BITS = 20;   // width of the saturating unit counter
  localparam int TOTAL_W    = 20;   // unit_total field width
  localparam int CAP_W      = 20;   // capacity_units register width
  localparam int UNIT_W     = 16;   // UTF-16 code unit
  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;   // code point accumulator
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int MAX_RES    = 3;    // results one byte can cause
  localparam int QDEPTH     = 4;    // job queue depth
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY = 1'b1;

  typedef enum logic [1:0] {
    KIND_UNIT   = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [UNIT_W-1:0]  code_unit;
    kind_t              kind;
    logic [TOTAL_W-1:0] unit_total;
  } res_t;

  // one accepted byte's worth of results, slot 0 goes out first
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         n;    // 1..3 results
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ===== design/u2u_if.sv =====
// ----------------------------------------------------------------------------
// u2u channel interfaces
// Input byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface u2u_in_if
  import u2u_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] source_byte;
  logic              end_of_buffer;

  modport source (output valid, output source_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input source_byte, input end_of_buffer, output ready);
endinterface

interface u2u_out_if
  import u2u_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [UNIT_W-1:0]  code_unit;
  logic [1:0]         kind;
  logic [TOTAL_W-1:0] unit_total;
  logic               last_of_run;

  modport source (output valid, output code_unit, output kind, output unit_total,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input kind, input unit_total,
                  input last_of_run, output ready);
endinterface

interface u2u_cfg_if
  import u2u_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/u2u_front.sv =====
// ----------------------------------------------------------------------------
// u2u_front: byte decoder and job builder
// Holds the sequence state and config, and turns each byte into a job record.
// ----------------------------------------------------------------------------
module u2u_front
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u2u_in_if.sink    in_s,
  u2u_cfg_if.sink   cfg_s,
  input  q_status_t q_stat,
  output logic      push,
  output job_t      job
);

  localparam int CMP_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [CAP_W-1:0]      cap_r;
  logic                  cnt_only_r;
  logic [CP_W-1:0]       acc_r, acc_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] units_r, units_nxt;
  logic                  err_r, err_nxt;

  logic                  in_acc;
  logic [BYTE_W-1:0]     b;
  logic                  eob;
  logic                  have_cp;
  logic [CP_W-1:0]       cp;
  logic [CP_W-1:0]       acc_shift;
  logic                  need2;
  logic [1:0]            need;
  logic [CP_W-1:0]       v;
  logic [CMP_W-1:0]      sum;
  logic                  err_new;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    return (x == COUNT_MAX) ? x : x + 1'b1;
  endfunction

  assign cfg_s.ready = 1'b1;
  assign in_s.ready  = !q_stat.full;
  assign in_acc      = in_s.valid && in_s.ready;
  assign b           = in_s.source_byte;
  assign eob         = in_s.end_of_buffer;

  assign acc_shift = {acc_r[CP_W-7:0], b[5:0]};

  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    units_nxt = units_r;
    err_nxt   = err_r;
    have_cp   = 1'b0;
    cp        = '0;
    need2     = 1'b0;
    need      = 2'd1;
    v         = '0;
    sum       = '0;
    err_new   = 1'b0;
    job       = '0;

    if (!err_r) begin
      if (pend_r == 2'd0) begin
        unique case (b) inside
          8'b0???????: begin
            cp      = CP_W'(b);
            have_cp = 1'b1;
          end
          8'b110?????: begin
            acc_nxt  = CP_W'(b[4:0]);
            pend_nxt = 2'd1;
          end
          8'b1110????: begin
            acc_nxt  = CP_W'(b[3:0]);
            pend_nxt = 2'd2;
          end
          8'b11110???: begin
            acc_nxt  = CP_W'(b[2:0]);
            pend_nxt = 2'd3;
          end
          default: err_new = 1'b1;
        endcase
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          cp      = acc_shift;
          acc_nxt = '0;
          have_cp = 1'b1;
        end
      end

      if (have_cp) begin
        need2 = |cp[CP_W-1:UNIT_W];
        need  = need2 ? 2'd2 : 2'd1;
        v     = cp - CP_W'(32'h10000);
        sum   = CMP_W'(units_r) + CMP_W'(need);
        if (cnt_only_r) begin
          units_nxt = need2 ? sat_inc(sat_inc(units_r)) : sat_inc(units_r);
        end else if (sum > CMP_W'(cap_r)) begin
          err_new = 1'b1;
        end else if (!need2) begin
          units_nxt                 = sat_inc(units_r);
          job.res[0].code_unit      = cp[UNIT_W-1:0];
          job.res[0].kind           = KIND_UNIT;
          job.res[0].unit_total     = TOTAL_W'(units_nxt);
          job.n                     = 2'd1;
        end else begin
          job.res[0].code_unit      = 16'hD800 + UNIT_W'(v[CP_W-1:10]);
          job.res[0].kind           = KIND_UNIT;
          job.res[0].unit_total     = TOTAL_W'(sat_inc(units_r));
          units_nxt                 = sat_inc(sat_inc(units_r));
          job.res[1].code_unit      = 16'hDC00 + UNIT_W'(v[9:0]);
          job.res[1].kind           = KIND_UNIT;
          job.res[1].unit_total     = TOTAL_W'(units_nxt);
          job.n                     = 2'd2;
        end
      end

      // cut short: end marker with bytes still pending
      if (!err_new && eob && pend_nxt != 2'd0) err_new = 1'b1;

      if (err_new) begin
        err_nxt                    = 1'b1;
        acc_nxt                    = '0;
        pend_nxt                   = 2'd0;
        job.res[job.n].code_unit   = '0;
        job.res[job.n].kind        = KIND_ERROR;
        job.res[job.n].unit_total  = TOTAL_W'(units_nxt);
        job.n                      = job.n + 2'd1;
      end else if (eob) begin
        job.res[job.n].code_unit   = '0;
        job.res[job.n].kind        = KIND_REPORT;
        job.res[job.n].unit_total  = TOTAL_W'(units_nxt);
        job.n                      = job.n + 2'd1;
      end
    end

    if (eob) begin
      acc_nxt   = '0;
      pend_nxt  = 2'd0;
      units_nxt = '0;
      err_nxt   = 1'b0;
    end
  end

  assign push = in_acc && (job.n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= '0;
      cnt_only_r <= 1'b0;
      acc_r      <= '0;
      pend_r     <= 2'd0;
      units_r    <= '0;
      err_r      <= 1'b0;
    end else begin
      if (cfg_s.valid && cfg_s.ready) begin
        unique case (cfg_s.index)
          CFG_CAPACITY:   cap_r      <= cfg_s.data[CAP_W-1:0];
          CFG_COUNT_ONLY: cnt_only_r <= cfg_s.data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        acc_r   <= acc_nxt;
        pend_r  <= pend_nxt;
        units_r <= units_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

// ===== design/u2u_fifo.sv =====
// ----------------------------------------------------------------------------
// u2u_fifo: job queue
// Small register queue that decouples the decoder from the result serializer.
// ----------------------------------------------------------------------------
module u2u_fifo
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      wr_job,
  input  logic      pop,
  output job_t      rd_job,
  output q_status_t stat
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/u2u_back.sv =====
// ----------------------------------------------------------------------------
// u2u_back: result serializer
// Sends the results of the head job one per transfer and then pops it.
// ----------------------------------------------------------------------------
module u2u_back
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_status_t q_stat,
  output logic      pop,
  u2u_out_if.source out_s
);

  logic [1:0] sel_r;
  logic       last;
  logic       xfer;
  res_t       cur;

  assign cur               = head.res[sel_r];
  assign last              = (sel_r == head.n - 2'd1);
  assign out_s.valid       = !q_stat.empty;
  assign out_s.code_unit   = cur.code_unit;
  assign out_s.kind        = cur.kind;
  assign out_s.unit_total  = cur.unit_total;
  assign out_s.last_of_run = last;
  assign xfer              = out_s.valid && out_s.ready;
  assign pop               = xfer && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
    end else if (xfer) begin
      sel_r <= last ? 2'd0 : sel_r + 2'd1;
    end
  end

endmodule

// ===== design/utf8_to_utf16_stream_converter.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_converter: streaming UTF-8 to UTF-16 transcoder
// Byte-in, result-out converter with unit counting and capacity checking.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle and produces UTF-16 code units, a final
// count report on the end-of-buffer byte, or one error result (bad lead byte,
// sequence cut short, capacity overflow); after an error, bytes are dropped
// without results until the end marker. A byte is taken every cycle as long
// as the 4-entry job queue has room; the result side sends one result per
// cycle while the receiver is ready, so a byte causing two or three
// results (surrogate pair, report) holds the output until all are sent,
// and the queue absorbs the burst; each job is registered in the queue. Config
// writes are always ready and must only be made while the block is idle.
module utf8_to_utf16_stream_converter
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u2u_in_if.sink    in_s,
  u2u_out_if.source out_s,
  u2u_cfg_if.sink   cfg_s
);

  // front -> queue
  logic      push;
  job_t      wr_job;
  // queue -> back
  job_t      head;
  logic      pop;
  q_status_t q_stat;

  // decode, sequence state, counters and config registers
  u2u_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_s),
    .cfg_s  (cfg_s),
    .q_stat (q_stat),
    .push   (push),
    .job    (wr_job)
  );

  // one job per byte that causes at least one result
  u2u_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (head),
    .stat   (q_stat)
  );

  // serializes each job into 1..3 result transfers
  u2u_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_s  (out_s)
  );

`ifndef SYNTH
  // reports and errors always close the run of a byte
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.kind != KIND_UNIT) |-> out_s.last_of_run)
    else $error("report/error result not marked last");

  // non-unit results carry a zero code unit
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.kind != KIND_UNIT) |-> (out_s.code_unit == '0))
    else $error("report/error result with nonzero code unit");

  // queue occupancy stays within depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("job queue overflow");
`endif

endmodule

// ===== test/utf8_to_utf16_stream_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_converter_tb: self-checking bench for the transcoder
// Byte stimulus feeds a local model of the converter; every result transfer is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_converter_tb;
  import u2u_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;    // covers the registered 4-deep job queue
  localparam int HOLD_LEN = 80;        // long result-side hold-off
  localparam int STALL_LIMIT = 1000;   // cycles with no transfer before giving up
  localparam int PHASE_BYTES = 40;

  // one source byte with its end-of-buffer flag
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } src_byte_t;

  // one predicted result
  typedef struct {
    logic [UNIT_W-1:0]  unit;
    kind_t              kind;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } unit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  u2u_in_if  in_if();
  u2u_out_if out_if();
  u2u_cfg_if cfg_if();

  utf8_to_utf16_stream_converter i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_s (cfg_if)
  );

  always #HALF_PERIOD clk = ~clk;

  // bytes waiting for the driver, results waiting for the DUT
  src_byte_t    src_bytes_q[$];
  unit_result_t unit_due_q[$];

  int err_count = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 55;
  int hold_asked = 0;   // bumped by the sequencer to request one long hold
  int quiet_cycles = 0;

  // converter model: state and registers
  logic [CP_W-1:0]    conv_acc = '0;
  logic [1:0]         conv_left = '0;
  logic [TOTAL_W-1:0] conv_units = '0;
  logic               conv_fault = 1'b0;
  logic [CAP_W-1:0]   reg_capacity = '0;
  logic               reg_count_only = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // saturating unit counter
  function automatic void count_unit();
    if (conv_units != {TOTAL_W{1'b1}})
      conv_units++;
  endfunction

  function automatic void clear_conv();
    conv_acc   = '0;
    conv_left  = '0;
    conv_units = '0;
    conv_fault = 1'b0;
  endfunction

  // Work out what one accepted byte produces and queue it.
  function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic eob);
    unit_result_t batch[$];
    unit_result_t r;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] v;
    logic have_cp;
    int need;
    have_cp = 1'b0;
    cp = '0;
    // latched fault: swallow everything, the end marker only clears
    if (conv_fault) begin
      if (eob)
        clear_conv();
      return;
    end
    if (conv_left == 2'd0) begin
      if (!b[7]) begin
        cp = {13'd0, b};
        have_cp = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        conv_acc = {16'd0, b[4:0]};
        conv_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        conv_acc = {17'd0, b[3:0]};
        conv_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        conv_acc = {18'd0, b[2:0]};
        conv_left = 2'd3;
      end else begin
        conv_fault = 1'b1;   // bad lead byte
      end
    end else begin
      // continuation: top bits ignored
      conv_acc = {conv_acc[14:0], b[5:0]};
      conv_left = conv_left - 2'd1;
      if (conv_left == 2'd0) begin
        cp = conv_acc;
        conv_acc = '0;
        have_cp = 1'b1;
      end
    end
    if (have_cp) begin
      need = (cp <= 21'h00FFFF) ? 1 : 2;
      r.total = '0;
      r.last = 1'b0;
      if (reg_count_only) begin
        count_unit();
        if (need == 2)
          count_unit();
      end else if (32'(conv_units) + need > 32'(reg_capacity)) begin
        conv_fault = 1'b1;   // capacity overflow
      end else if (need == 1) begin
        count_unit();
        r.unit = cp[15:0];
        r.kind = KIND_UNIT;
        r.total = conv_units;
        batch.push_back(r);
      end else begin
        v = cp - 21'h010000;
        count_unit();
        r.unit = 16'hD800 + {5'd0, v[20:10]};
        r.kind = KIND_UNIT;
        r.total = conv_units;
        batch.push_back(r);
        count_unit();
        r.unit = 16'hDC00 + {6'd0, v[9:0]};
        r.total = conv_units;
        batch.push_back(r);
      end
    end
    // end marker in the middle of a sequence
    if (!conv_fault && eob && conv_left != 2'd0)
      conv_fault = 1'b1;
    if (conv_fault) begin
      conv_acc = '0;
      conv_left = '0;
      r.unit = '0;
      r.kind = KIND_ERROR;
      r.total = conv_units;
      r.last = 1'b0;
      batch.push_back(r);
    end else if (eob) begin
      r.unit = '0;
      r.kind = KIND_REPORT;
      r.total = conv_units;
      r.last = 1'b0;
      batch.push_back(r);
    end
    if (batch.size() > 0)
      batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i])
      unit_due_q.push_back(batch[i]);
    if (eob)
      clear_conv();
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes, holds an offer until its transfer, and feeds
  // every transferred byte to the model. valid gets at most one update a step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    src_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        predict_byte(in_if.source_byte, in_if.end_of_buffer);
      // a pending offer stays put until the DUT takes it
      if (!in_if.valid || in_if.ready) begin
        if (src_bytes_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = src_bytes_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.source_byte <= nxt.value;
          in_if.end_of_buffer <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer and drives ready, with random stalls
  // and, on request, one long hold that lets the DUT's job queue fill.
  // --------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    unit_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (unit_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d unit %h total %0d",
                                  out_if.kind, out_if.code_unit, out_if.unit_total));
      end else begin
        want = unit_due_q.pop_front();
        if (out_if.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_if.kind, want.kind));
        if (out_if.code_unit !== want.unit)
          report_mismatch($sformatf("code_unit %h, want %h", out_if.code_unit, want.unit));
        if (out_if.unit_total !== want.total)
          report_mismatch($sformatf("unit_total %0d, want %0d",
                                    out_if.unit_total, want.total));
        if (out_if.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_if.last_of_run, want.last));
      end
    end
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: any transfer on any channel resets the quiet count
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT)
      @(posedge clk);
    $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("utf8_to_utf16_stream_converter_tb: errors");
    $finish;
  end

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic eob);
    src_byte_t s;
    s.value = b;
    s.last = eob;
    src_bytes_q.push_back(s);
  endfunction

  // One random buffer: mostly well-formed code points with random payload,
  // some noise bytes, sloppy continuations and the odd truncated tail.
  function automatic int queue_buffer();
    logic [BYTE_W-1:0] seq[$];
    logic [BYTE_W-1:0] rb;
    int n_cp;
    int len;
    int keep;
    n_cp = $urandom_range(1, 6);
    for (int i = 0; i < n_cp; i++) begin
      rb = BYTE_W'($urandom);
      if ($urandom_range(99) < 8) begin
        seq.push_back(rb);
      end else begin
        len = $urandom_range(1, 4);
        keep = len;
        if (i == n_cp - 1 && len > 1 && $urandom_range(99) < 12)
          keep = $urandom_range(1, len - 1);
        case (len)
          1: seq.push_back({1'b0, rb[6:0]});
          2: seq.push_back({3'b110, rb[4:0]});
          3: seq.push_back({4'b1110, rb[3:0]});
          default: seq.push_back({5'b11110, rb[2:0]});
        endcase
        for (int k = 1; k < keep; k++) begin
          rb = BYTE_W'($urandom);
          if ($urandom_range(7) == 0)
            seq.push_back(rb);
          else
            seq.push_back({2'b10, rb[5:0]});
        end
      end
    end
    foreach (seq[i])
      push_byte(seq[i], i == seq.size() - 1);
    return seq.size();
  endfunction

  // wait until nothing is queued, offered or expected, then let the DUT go quiet
  task automatic settle();
    while (src_bytes_q.size() != 0 || in_if.valid || unit_due_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back, then drop valid once
  task automatic set_regs(input logic [CAP_W-1:0] cap, input logic cnt_only);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_CAPACITY;
    cfg_if.data <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    reg_capacity = cap;
    cfg_if.index <= CFG_COUNT_ONLY;
    cfg_if.data <= {{(CFG_DATA_W - 1){1'b0}}, cnt_only};
    do @(posedge clk); while (!cfg_if.ready);
    reg_count_only = cnt_only;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes)
      sent += queue_buffer();
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid = 1'b0;
    in_if.source_byte = '0;
    in_if.end_of_buffer = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_CAPACITY;
    cfg_if.data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full capacity, each sequence length, byte extremes
    set_regs({CAP_W{1'b1}}, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // beyond U+10FFFF still goes out as a pair
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    // bad lead, then dropped bytes up to and including the end marker
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b1);
    // truncated three-byte sequence
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    // five-byte lead on the end marker
    push_byte(8'hF8, 1'b1);
    settle();

    // room for one unit only: the pair overflows
    set_regs(20'd1, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    settle();

    // count only, capacity ignored
    set_regs(20'd0, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h9F, 1'b0);
    push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h61, 1'b1);
    settle();

    // random, tight capacity so overflows are common
    set_regs(20'($urandom_range(0, 24)), 1'b0);
    random_phase(PHASE_BYTES);
    settle();

    // swap idling, full capacity, one long hold to back up the job queue
    tx_idle_pct = 55;
    rx_idle_pct = 13;
    set_regs({CAP_W{1'b1}}, 1'b0);
    hold_asked++;
    random_phase(PHASE_BYTES);
    settle();

    // no idling: count only, then a mid-size capacity
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_regs(20'd0, 1'b1);
    random_phase(PHASE_BYTES / 2);
    settle();
    set_regs(20'($urandom_range(16, 64)), 1'b0);
    random_phase(PHASE_BYTES / 2);
    settle();

    if (err_count == 0)
      $display("utf8_to_utf16_stream_converter_tb: clean");
    else
      $display("utf8_to_utf16_stream_converter_tb: errors");
    $finish;
  end

endmodule
